/* design/ins_sort_pkg.sv */
// Package with shared constants and controller/datapath interface types of the insertion sorter.
package ins_sort_pkg;

    // Default capacity and stored value width.
    localparam int unsigned DEPTH_DEF      = 32;
    localparam int unsigned DATA_WIDTH_DEF = 32;
    // Width of the external value ports.
    localparam int unsigned PORT_WIDTH     = 32;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic ins;    // insert the offered value
        logic shift;  // shift the store down by one entry
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_one;  // exactly one entry held
    } t_status;

endpackage

/* design/ins_sort_ctrl.sv */
// Controller state machine of the insertion sorter: collect values, then emit the set.
module ins_sort_ctrl
    import ins_sort_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  logic    i_in_last,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    busy,
    output logic    o_strobe
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        o_cmd.ins   = 1'b0;
        o_cmd.shift = 1'b0;
        busy        = 1'b0;
        o_strobe    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.ins = 1'b1;
                    if (i_in_last) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                busy        = 1'b1;
                o_strobe    = 1'b1;
                o_cmd.shift = 1'b1;
                if (i_status.count_one) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // Emission always ends on a single held entry and returns to idle.
    a_emit_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) && i_status.count_one |=> (r_state == ST_IDLE))
        else $error("controller did not leave emission after the final beat");
    // Insert and shift are never commanded together.
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.ins && o_cmd.shift))
        else $error("insert and shift commanded in the same cycle");
    // A last item that is taken starts emission in the next cycle.
    a_last_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_in_last |=> o_strobe)
        else $error("emission did not follow a last item");
`endif

endmodule

/* design/ins_sort_dp.sv */
// Datapath of the insertion sorter: chain of compare-and-shift cells, fill count and overflow flag.
module ins_sort_dp
    import ins_sort_pkg::*;
#(
    parameter int unsigned DEPTH      = DEPTH_DEF,
    parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cmd                         i_cmd,
    input  logic signed [PORT_WIDTH-1:0] i_in_value,
    output t_status                      o_status,
    output logic signed [PORT_WIDTH-1:0] o_out_value,
    output logic                         o_out_last,
    output logic                         o_out_dropped
);

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned XW = (DATA_WIDTH > PORT_WIDTH) ? DATA_WIDTH : PORT_WIDTH;

    logic signed [DATA_WIDTH-1:0] r_store [DEPTH];
    logic signed [DATA_WIDTH-1:0] n_store [DEPTH];
    logic [CW-1:0]                r_count;
    logic [CW-1:0]                n_count;
    logic                         r_overflow;
    logic                         n_overflow;

    logic signed [XW-1:0]         in_ext;
    logic signed [DATA_WIDTH-1:0] new_val;
    logic signed [XW-1:0]         out_ext;
    logic [DEPTH-1:0]             gt;
    logic                         full;
    logic                         do_ins;

    // Input value widened, then cut to the stored width.
    assign in_ext  = XW'(i_in_value);
    assign new_val = in_ext[DATA_WIDTH-1:0];

    assign full     = (r_count == CW'(DEPTH));
    assign do_ins   = i_cmd.ins && !full;

    // Each cell compares its held value with the new one; ties keep arrival order.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            gt[i] = (CW'(i) < r_count) && (r_store[i] > new_val);
        end
    end

    // Next contents of the cell chain.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_store[i] = r_store[i];
            if (i_cmd.shift) begin
                if (i < DEPTH - 1) begin
                    n_store[i] = r_store[(i + 1) % DEPTH];
                end
            end else if (do_ins) begin
                if ((i > 0) && gt[(i + DEPTH - 1) % DEPTH]) begin
                    n_store[i] = r_store[(i + DEPTH - 1) % DEPTH];
                end else if (gt[i] || (CW'(i) == r_count)) begin
                    n_store[i] = new_val;
                end
            end
        end
    end

    // Fill count and overflow flag.
    always_comb begin
        n_count    = r_count;
        n_overflow = r_overflow;
        if (i_cmd.shift) begin
            n_count = r_count - CW'(1);
            if (r_count == CW'(1)) begin
                n_overflow = 1'b0;
            end
        end else if (i_cmd.ins) begin
            if (full) begin
                n_overflow = 1'b1;
            end else begin
                n_count = r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            r_store[i] <= n_store[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_overflow <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_overflow <= n_overflow;
        end
    end

    // Status and result beat taken from the head cell.
    assign o_status.count_one = (r_count == CW'(1));
    assign out_ext            = XW'(r_store[0]);
    assign o_out_value        = out_ext[PORT_WIDTH-1:0];
    assign o_out_last         = o_status.count_one;
    assign o_out_dropped      = o_status.count_one && r_overflow;

`ifndef SYNTHESIS
    // The fill count never passes the capacity.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count beyond capacity");
    // Shifting out happens only while entries are held.
    a_shift_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.shift |-> (r_count != '0))
        else $error("shift with an empty store");
    // An insert into a store with room grows the count by one.
    a_ins_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins && !full |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the fill count");
`endif

endmodule

/* design/insertion_sorter_unit.sv */
// Top level of the insertion sorter: controller and cell-chain datapath.
//
//   Channel  Direction  Handshake                  Payload
//   item     in         start high, busy low       i_in_value, i_in_last
//   result   out        o_strobe high              o_out_value, o_out_last, o_out_dropped
//
// An item is taken while busy is low; the cell chain compares and shifts in parallel, so
// items without the last mark may follow back to back.
// After a last item, the set leaves one beat a cycle from the head cell, and busy stays
// high until the last beat has left.
// Reset is synchronous and active low; it empties the store and clears the overflow flag.
// The receiver cannot stall: every beat is taken in the cycle its strobe is high.
module insertion_sorter_unit
    import ins_sort_pkg::*;
#(
    parameter int unsigned DEPTH      = DEPTH_DEF,
    parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [PORT_WIDTH-1:0] i_in_value,
    input  logic                         i_in_last,
    output logic                         o_strobe,
    output logic signed [PORT_WIDTH-1:0] o_out_value,
    output logic                         o_out_last,
    output logic                         o_out_dropped
);

    t_cmd    cmd;
    t_status status;

    // Sequencing of collection and emission.
    ins_sort_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_in_last (i_in_last),
        .i_status  (status),
        .o_cmd     (cmd),
        .busy      (busy),
        .o_strobe  (o_strobe)
    );

    // Sorted store and counters.
    ins_sort_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_in_value    (i_in_value),
        .o_status      (status),
        .o_out_value   (o_out_value),
        .o_out_last    (o_out_last),
        .o_out_dropped (o_out_dropped)
    );

endmodule

/* verif/sort_scoreboard_pkg.sv */
// Scoreboard class for the insertion sorter: sorted-set predictor and beat checker.
package sort_scoreboard_pkg;

    import ins_sort_pkg::*;

    // One expected output beat.
    typedef struct {
        logic [PORT_WIDTH-1:0] value;
        logic                  last;
        logic                  dropped;
    } t_sorted_beat;

    class sort_scoreboard;

        // Predicted store contents, kept ascending, at the stored width sign-extended to 64.
        logic signed [63:0] held_vals[$];
        bit                 overflow;
        t_sorted_beat       expected_beats[$];
        int unsigned        fail_count;

        function new();
            overflow   = 1'b0;
            fail_count = 0;
        endfunction

        // Count a failure; only the first ten are printed.
        function void flag(string msg);
            fail_count++;
            if (fail_count <= 10) begin
                $display("%s", msg);
            end
        endfunction

        function int unsigned pending();
            return expected_beats.size();
        endfunction

        // An accepted input beat: insert it, and on a last beat queue the whole sorted set.
        function void note_item(logic signed [PORT_WIDTH-1:0] value, logic last);
            logic signed [63:0]             wide;
            logic signed [DATA_WIDTH_DEF-1:0] narrow;
            logic signed [63:0]             stored;
            int                             pos;
            t_sorted_beat                   beat;
            wide   = value;
            narrow = wide[DATA_WIDTH_DEF-1:0];
            stored = narrow;
            // A full store drops the value, even when it carries the last mark.
            if (held_vals.size() >= DEPTH_DEF) begin
                overflow = 1'b1;
            end else begin
                // Equal values stay in arrival order: the new one goes after them.
                pos = held_vals.size();
                while (pos > 0 && held_vals[pos-1] > stored) begin
                    pos--;
                end
                held_vals.insert(pos, stored);
            end
            if (last) begin
                foreach (held_vals[i]) begin
                    beat.value   = held_vals[i][PORT_WIDTH-1:0];
                    beat.last    = (i == held_vals.size() - 1);
                    beat.dropped = beat.last && overflow;
                    expected_beats.push_back(beat);
                end
                held_vals.delete();
                overflow = 1'b0;
            end
        endfunction

        // An output beat: compare with the oldest expected one.
        function void check_beat(logic [PORT_WIDTH-1:0] value, logic last, logic dropped);
            t_sorted_beat exp_beat;
            if (expected_beats.size() == 0) begin
                flag($sformatf("Unexpected beat: value %0d last %0b dropped %0b",
                               $signed(value), last, dropped));
                return;
            end
            exp_beat = expected_beats.pop_front();
            if (value !== exp_beat.value || last !== exp_beat.last
                    || dropped !== exp_beat.dropped) begin
                flag($sformatf({"Beat mismatch: expected value %0d last %0b dropped %0b,",
                                " got value %0d last %0b dropped %0b"},
                               $signed(exp_beat.value), exp_beat.last, exp_beat.dropped,
                               $signed(value), last, dropped));
            end
        endfunction

        // Anything still queued at the end never came out.
        function void check_drained();
            if (expected_beats.size() != 0) begin
                flag($sformatf("%0d sorted beats never arrived", expected_beats.size()));
            end
        endfunction

    endclass

endpackage

/* verif/testbench.sv */
// Testbench for the insertion sorter: directed and random sets checked against a predictor.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import ins_sort_pkg::*;
    import sort_scoreboard_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned ITEMS_PER_PHASE = 60;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    logic signed [PORT_WIDTH-1:0] i_in_value;
    logic                         i_in_last;
    logic                         o_strobe;
    logic signed [PORT_WIDTH-1:0] o_out_value;
    logic                         o_out_last;
    logic                         o_out_dropped;

    sort_scoreboard               sb = new();
    logic signed [PORT_WIDTH-1:0] set_vals[$];
    int unsigned                  cycle_count = 0;
    int unsigned                  items_sent;
    int unsigned                  set_index;
    int                           gap_pcts[3] = '{0, 45, 11};

    insertion_sorter_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_in_value    (i_in_value),
        .i_in_last     (i_in_last),
        .o_strobe      (o_strobe),
        .o_out_value   (o_out_value),
        .o_out_last    (o_out_last),
        .o_out_dropped (o_out_dropped)
    );

    // 12 ns clock.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Monitor: values seen here are the ones from before this edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) begin
                sb.check_beat(o_out_value, o_out_last, o_out_dropped);
            end
            if (start && !busy) begin
                sb.note_item(i_in_value, i_in_last);
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Offer one input beat and hold it until the block takes it.
    task automatic send_item(input logic signed [PORT_WIDTH-1:0] value, input logic last);
        start      <= 1'b1;
        i_in_value <= value;
        i_in_last  <= last;
        do @(posedge i_clk); while (busy);
    endtask

    // Sender gap, with noise on the payload, pct times in a hundred.
    task automatic pause_sender(input int pct);
        if ($urandom_range(99) < pct) begin
            start      <= 1'b0;
            i_in_value <= $urandom;
            i_in_last  <= $urandom_range(1);
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Send set_vals as one set, the final beat marked last.
    task automatic play_set(input int pct);
        foreach (set_vals[i]) begin
            send_item(set_vals[i], i == set_vals.size() - 1);
            items_sent++;
            pause_sender(pct);
        end
    endtask

    // Hold the sender off until every expected beat has come out.
    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Mostly full-range values, with extremes and a narrow band that makes ties.
    function automatic logic signed [PORT_WIDTH-1:0] pick_value();
        case ($urandom_range(7))
            0: begin
                case ($urandom_range(3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            1, 2: return $urandom_range(8) - 4;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int unsigned set_len;
        start      <= 1'b0;
        i_in_value <= '0;
        i_in_last  <= 1'b0;
        i_rst_n    <= 1'b0;
        items_sent = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed sets: a lone minimum, extremes mixed, ties, sorted and reversed input.
        set_vals = {32'sh8000_0000};
        play_set(0);
        set_vals = {32'sh7fff_ffff, 32'sh8000_0000, 32'sd0, -32'sd1, 32'sd1};
        play_set(0);
        set_vals = {32'sd5, -32'sd3, 32'sd5, 32'sd5, -32'sd3};
        play_set(0);
        set_vals = {-32'sd8, -32'sd2, 32'sd4, 32'sd9};
        play_set(0);
        set_vals = {32'sd9, 32'sd4, -32'sd2, -32'sd8, -32'sd9};
        play_set(0);
        wait_drained();

        // Random sets in phases of sender idling. The first is one past capacity so the
        // last beat itself is dropped; the second fills the store exactly.
        set_index = 0;
        foreach (gap_pcts[p]) begin
            items_sent = 0;
            while (items_sent < ITEMS_PER_PHASE) begin
                if (set_index == 0) begin
                    set_len = DEPTH_DEF + 1;
                end else if (set_index == 1) begin
                    set_len = DEPTH_DEF;
                end else if ($urandom_range(9) == 0) begin
                    set_len = $urandom_range(DEPTH_DEF + 8, DEPTH_DEF - 2);
                end else begin
                    set_len = $urandom_range(8, 1);
                end
                set_vals.delete();
                repeat (set_len) set_vals.push_back(pick_value());
                play_set(gap_pcts[p]);
                set_index++;
            end
            wait_drained();
        end

        // Let any stray beat show up before the final check.
        repeat (DEPTH_DEF + 8) @(posedge i_clk);
        sb.check_drained();
        if (sb.fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
